// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file pkc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PKC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define PKC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `PKC_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

// Check that a condition implies another one in the next cycle.
`define PKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `PKC_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/pkc_pkg.sv =====
`timescale 1ns / 1ps

package pkc_pkg;

   localparam int unsigned TickWidth     = 32;
   localparam int unsigned CfgWidth      = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned StateWidth    = 3;
   localparam int unsigned ClassWidth    = 2;
   localparam int unsigned PowerWidth    = 2;

   // Classifier machine states
   localparam logic [StateWidth-1:0] ST_WAIT    = 3'd0;
   localparam logic [StateWidth-1:0] ST_DETECT  = 3'd1;
   localparam logic [StateWidth-1:0] ST_RELEASE = 3'd2;
   localparam logic [StateWidth-1:0] ST_SHORT   = 3'd3;
   localparam logic [StateWidth-1:0] ST_LONG    = 3'd4;
   localparam logic [StateWidth-1:0] ST_DOUBLE  = 3'd5;
   localparam logic [StateWidth-1:0] ST_END     = 3'd6;

   // Press classes
   localparam logic [ClassWidth-1:0] CLS_NONE   = 2'd0;
   localparam logic [ClassWidth-1:0] CLS_SHORT  = 2'd1;
   localparam logic [ClassWidth-1:0] CLS_LONG   = 2'd2;
   localparam logic [ClassWidth-1:0] CLS_DOUBLE = 2'd3;

   // Module power states
   localparam logic [PowerWidth-1:0] PWR_OFF = 2'd0;
   localparam logic [PowerWidth-1:0] PWR_ON  = 2'd1;

   // Control register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_WINDOW = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SHORT_CLICK  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_PRESS   = 2'd2;

   // Control register reset values
   localparam logic [CfgWidth-1:0] PRESS_WINDOW_RESET = 16'd50;
   localparam logic [CfgWidth-1:0] SHORT_CLICK_RESET  = 16'd50;
   localparam logic [CfgWidth-1:0] LONG_PRESS_RESET   = 16'd4000;

   typedef struct packed {
      logic [CfgWidth-1:0] press_window_ms;
      logic [CfgWidth-1:0] short_click_ms;
      logic [CfgWidth-1:0] long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic [TickWidth-1:0]  now_ms;
      logic                  key_edge;
      logic                  key_released;
      logic [PowerWidth-1:0] power_state;
   } req_type;

   typedef struct packed {
      logic                  power_on_request;
      logic                  power_off_request;
      logic [ClassWidth-1:0] press_class;
      logic                  busy_res;
   } rsp_type;

endpackage

// ===== hw/rtl/pkc_req_if.sv =====
`timescale 1ns / 1ps

interface pkc_req_if;
   import pkc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TickWidth-1:0]  now_ms;
   logic                  key_edge;
   logic                  key_released;
   logic [PowerWidth-1:0] power_state;

   modport source (output valid, output now_ms, output key_edge, output key_released,
                   output power_state, input ready);
   modport sink (input valid, input now_ms, input key_edge, input key_released,
                 input power_state, output ready);
   modport monitor (input valid, input ready, input now_ms, input key_edge,
                    input key_released, input power_state);
endinterface

// ===== hw/rtl/pkc_rsp_if.sv =====
`timescale 1ns / 1ps

interface pkc_rsp_if;
   import pkc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  power_on_request;
   logic                  power_off_request;
   logic [ClassWidth-1:0] press_class;
   logic                  busy_res;

   modport source (output valid, output power_on_request, output power_off_request,
                   output press_class, output busy_res, input ready);
   modport sink (input valid, input power_on_request, input power_off_request,
                 input press_class, input busy_res, output ready);
   modport monitor (input valid, input ready, input power_on_request,
                    input power_off_request, input press_class, input busy_res);
endinterface

// ===== hw/rtl/pkc_csr.sv =====
`timescale 1ns / 1ps

module pkc_csr import pkc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]      csr_write_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register write; unused indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PRESS_WINDOW: cfg_in.press_window_ms = csr_write_data;
            CSR_SHORT_CLICK:  cfg_in.short_click_ms  = csr_write_data;
            CSR_LONG_PRESS:   cfg_in.long_press_ms   = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_window_ms <= PRESS_WINDOW_RESET;
         cfg_ff.short_click_ms  <= SHORT_CLICK_RESET;
         cfg_ff.long_press_ms   <= LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pkc_fsm.sv =====
`timescale 1ns / 1ps

module pkc_fsm import pkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int unsigned PadWidth = TickWidth - CfgWidth;

   logic [StateWidth-1:0] state_ff;
   logic [StateWidth-1:0] state_in;
   logic [TickWidth-1:0]  press_start_ff;
   logic [TickWidth-1:0]  press_start_in;
   logic [TickWidth-1:0]  release_time_ff;
   logic [TickWidth-1:0]  release_time_in;

   logic [StateWidth-1:0] cur_state;
   logic [TickWidth-1:0]  held;
   logic [TickWidth-1:0]  since_release;
   logic [TickWidth-1:0]  press_len;
   logic [TickWidth-1:0]  win_ext;
   logic [TickWidth-1:0]  short_ext;
   logic [TickWidth-1:0]  long_ext;

   // Fold unused codes back to waiting; an edge restarts the press time
   always_comb begin
      cur_state      = (state_ff > ST_END) ? ST_WAIT : state_ff;
      press_start_in = item.key_edge ? item.now_ms : press_start_ff;
      held           = item.now_ms - press_start_in;
      since_release  = item.now_ms - release_time_ff;
      press_len      = release_time_ff - press_start_in;
      win_ext        = {{PadWidth{1'b0}}, cfg.press_window_ms};
      short_ext      = {{PadWidth{1'b0}}, cfg.short_click_ms};
      long_ext       = {{PadWidth{1'b0}}, cfg.long_press_ms};
   end

   // Advance the classifier one step for this poll
   always_comb begin
      state_in                 = cur_state;
      release_time_in          = release_time_ff;
      result.power_on_request  = 1'b0;
      result.power_off_request = 1'b0;
      result.press_class       = CLS_NONE;
      unique case (cur_state)
         ST_WAIT: begin
            if (item.key_edge) state_in = ST_DETECT;
         end
         ST_DETECT: begin
            priority if (item.key_released) begin
               release_time_in = item.now_ms;
               state_in        = ST_RELEASE;
            end else if (held > long_ext) begin
               state_in = ST_LONG;
            end else if (item.power_state == PWR_OFF && held >= win_ext) begin
               state_in = ST_SHORT;
            end
         end
         ST_RELEASE: begin
            priority if (!item.key_released && since_release <= win_ext) begin
               state_in = ST_DOUBLE;
            end else if (press_len <= win_ext) begin
               state_in = ST_DOUBLE;
            end else if (held >= long_ext) begin
               state_in = ST_END;
            end else if (held >= short_ext) begin
               state_in = ST_SHORT;
            end else begin
               state_in = ST_DOUBLE;
            end
         end
         ST_SHORT: begin
            result.press_class      = CLS_SHORT;
            result.power_on_request = (item.power_state != PWR_ON);
            state_in                = ST_END;
         end
         ST_LONG: begin
            result.press_class       = CLS_LONG;
            result.power_off_request = (item.power_state == PWR_ON);
            state_in                 = ST_END;
         end
         ST_DOUBLE: begin
            result.press_class = CLS_DOUBLE;
            state_in           = ST_END;
         end
         default: begin
            // End: wait for the key to come back up
            if (item.key_released) begin
               release_time_in = item.now_ms;
               state_in        = ST_WAIT;
            end
         end
      endcase
      result.busy_res = (state_in != ST_WAIT);
   end

   // Commit the step when the poll moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_WAIT;
         press_start_ff  <= '0;
         release_time_ff <= '0;
      end else if (step_en) begin
         state_ff        <= state_in;
         press_start_ff  <= press_start_in;
         release_time_ff <= release_time_in;
      end
   end

endmodule

// ===== hw/rtl/power_key_press_classifier_unit.sv =====
`timescale 1ns / 1ps

// Path: a poll is registered in the input register, classified combinationally
// and then registered again in the result register.
// Throughput: one poll per cycle while rsp is not stalled; a stalled result
// register holds the next poll in the input register.
// Reset (synchronous, active high): machine waiting, press and release times
// zero, control registers at their defaults, both stages empty.
module power_key_press_classifier_unit import pkc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pkc_req_if.sink                  req_chan,
   pkc_rsp_if.source                rsp_chan,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]      csr_write_data
);

   cfg_type cfg;
   rsp_type step_result;

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_item_ff;
   req_type req_item_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type rsp_item_in;
   logic    advance;
   logic    req_take;

   pkc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   pkc_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (req_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // Move a poll on when the result register is free or being drained
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Input stage
   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !advance);
      req_item_in  = req_item_ff;
      if (req_take) begin
         req_item_in.now_ms       = req_chan.now_ms;
         req_item_in.key_edge     = req_chan.key_edge;
         req_item_in.key_released = req_chan.key_released;
         req_item_in.power_state  = req_chan.power_state;
      end
   end

   // Result stage
   always_comb begin
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
      rsp_item_in  = advance ? step_result : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.power_on_request  = rsp_item_ff.power_on_request;
   assign rsp_chan.power_off_request = rsp_item_ff.power_off_request;
   assign rsp_chan.press_class       = rsp_item_ff.press_class;
   assign rsp_chan.busy_res          = rsp_item_ff.busy_res;

endmodule

// ===== hw/rtl/pkc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkc_checker import pkc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_power_on_request,
   input  logic                  rsp_power_off_request,
   input  logic [ClassWidth-1:0] rsp_press_class,
   input  logic                  rsp_busy_res
);

   logic [ClassWidth+2:0] rsp_bits;

   // Gather the result payload for the hold check
   assign rsp_bits = {rsp_power_on_request, rsp_power_off_request, rsp_press_class,
                      rsp_busy_res};

   // A stalled result keeps its contents until transferred
   `PKC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits), "stalled rsp changed")

   // Power-on only comes with a short press
   `PKC_ASSERT_IMP(a_on_short, clock, reset, rsp_valid && rsp_power_on_request, rsp_press_class == CLS_SHORT, "power-on without short")

   // Power-off only comes with a long press
   `PKC_ASSERT_IMP(a_off_long, clock, reset, rsp_valid && rsp_power_off_request, rsp_press_class == CLS_LONG, "power-off without long")

   // A classification leaves the machine busy until release
   `PKC_ASSERT_IMP(a_class_busy, clock, reset, rsp_valid && rsp_press_class != CLS_NONE, rsp_busy_res, "class while idle")

endmodule

bind power_key_press_classifier_unit pkc_checker u_pkc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_power_on_request  (rsp_chan.power_on_request),
   .rsp_power_off_request (rsp_chan.power_off_request),
   .rsp_press_class       (rsp_chan.press_class),
   .rsp_busy_res          (rsp_chan.busy_res)
);
